FILE: design/amrb_pkg.sv
package amrb_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 2048;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int DIST_W     = IDX_W + 1;

  localparam int LEVEL_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int MARGIN_W   = 10;
  localparam int COUNT_W    = 32;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(256);
  localparam logic [LEVEL_W-1:0]  MIN_RESET    = '1;
  localparam int                  MIX_GAIN     = 3;

  // Item actions
  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_PLAY    = 2'd1,
    ACT_SILENCE = 2'd2,
    ACT_EMPTY   = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [CHAN_W-1:0]   chan_a;
    logic [CHAN_W-1:0]   chan_b;
    logic [CHAN_W-1:0]   chan_c;
    logic [CHAN_W-1:0]   chan_d;
    logic [CHAN_W-1:0]   chan_e;
    logic                frame_first;
    logic                frame_last;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  dac_level;
    logic [LEVEL_W-1:0]  peak_to_peak;
    logic                p2p_valid;
    logic                resynced;
    logic [COUNT_W-1:0]  resync_count;
  } result_t;

endpackage

FILE: design/audio_mix_ring_buffer_resync.sv
// Audio sample ring: pushes mix five channels into a 2048-entry store, play ticks read
// it back for the DAC, and the first push of a frame (or an empty-frame item) pulls the
// write index half a ring ahead of the read index when the two come within the margin.
// After reset the store is cleared by a sweep over every entry, during which item_stall
// is high; configuration writes are taken at any time. Each item is then captured in
// the idle state (also starting the store read at the read index) and executed in the
// exec state against the store, loading the result register. A silence fill then
// sweeps every store entry again, one store entry per cycle, before the next item.
// The result register lets a new item be captured while the previous result waits.
module audio_mix_ring_buffer_resync (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [amrb_pkg::MARGIN_W-1:0]      cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  amrb_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output amrb_pkg::result_t                  result
);

  localparam int IDX_W      = amrb_pkg::IDX_W;
  localparam int DIST_W     = amrb_pkg::DIST_W;
  localparam int LEVEL_W    = amrb_pkg::LEVEL_W;
  localparam int CHAN_SUM_W = amrb_pkg::CHAN_W + 3;

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(amrb_pkg::RING_DEPTH - 1);
  localparam logic [IDX_W-1:0]  IDX_HALF = IDX_W'(amrb_pkg::RING_DEPTH / 2);
  localparam logic [DIST_W-1:0] DEPTH_D  = DIST_W'(amrb_pkg::RING_DEPTH);

  amrb_pkg::state_t state, state_next;

  logic [LEVEL_W-1:0]           sample_store [amrb_pkg::RING_DEPTH];
  logic [LEVEL_W-1:0]           rd_data;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_addr;
  logic [LEVEL_W-1:0]           mem_wdata;

  amrb_pkg::item_t              item_q;
  logic [amrb_pkg::MARGIN_W-1:0] resync_margin;
  logic [IDX_W-1:0]             write_index;
  logic [IDX_W-1:0]             read_index;
  logic [IDX_W-1:0]             sweep_idx;
  logic [LEVEL_W-1:0]           last_level;
  logic [LEVEL_W-1:0]           frame_min;
  logic [LEVEL_W-1:0]           frame_max;
  logic [amrb_pkg::COUNT_W-1:0] resync_total;

  logic                         slot_free;
  logic                         exec_go;
  logic                         sweep_end;

  // Datapath values for the item in execution
  logic [CHAN_SUM_W-1:0]        chan_sum;
  logic [CHAN_SUM_W+1:0]        mix_full;
  logic [LEVEL_W-1:0]           mix_level;
  logic [DIST_W-1:0]            fwd_gap;
  logic [DIST_W-1:0]            dist_back;
  logic [DIST_W-1:0]            half_ahead;
  logic                         near;
  logic                         do_check;
  logic                         do_resync;
  logic [IDX_W-1:0]             push_index;
  logic [IDX_W-1:0]             push_index_inc;
  logic [LEVEL_W-1:0]           base_min;
  logic [LEVEL_W-1:0]           base_max;
  logic [LEVEL_W-1:0]           new_min;
  logic [LEVEL_W-1:0]           new_max;
  amrb_pkg::result_t            result_next;

  assign cfg_ready = 1'b1;
  assign slot_free = !result_valid || !result_stall;
  assign sweep_end = (sweep_idx == IDX_LAST);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      resync_margin <= amrb_pkg::MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      resync_margin <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      amrb_pkg::ST_SWEEP: begin
        if (sweep_end) state_next = amrb_pkg::ST_IDLE;
      end
      amrb_pkg::ST_IDLE: begin
        if (item_valid) state_next = amrb_pkg::ST_EXEC;
      end
      amrb_pkg::ST_EXEC: begin
        if (slot_free) begin
          state_next = (item_q.action == amrb_pkg::ACT_SILENCE) ?
                       amrb_pkg::ST_SWEEP : amrb_pkg::ST_IDLE;
        end
      end
      default: state_next = amrb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and store port control
  always_comb begin
    item_stall = 1'b1;
    exec_go    = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = sweep_idx;
    mem_wdata  = last_level;
    unique case (state)
      amrb_pkg::ST_SWEEP: begin
        mem_we = 1'b1;
      end
      amrb_pkg::ST_IDLE: begin
        item_stall = 1'b0;
      end
      amrb_pkg::ST_EXEC: begin
        exec_go = slot_free;
        if (slot_free && item_q.action == amrb_pkg::ACT_PUSH) begin
          mem_we    = 1'b1;
          mem_addr  = push_index;
          mem_wdata = mix_level;
        end
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  // Sample store; the read port follows the read index every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_store[mem_addr] <= mem_wdata;
    end
    rd_data <= sample_store[read_index];
  end

  // Five-channel mix, scaled by three
  assign chan_sum = CHAN_SUM_W'(item_q.chan_a) + CHAN_SUM_W'(item_q.chan_b)
                  + CHAN_SUM_W'(item_q.chan_c) + CHAN_SUM_W'(item_q.chan_d)
                  + CHAN_SUM_W'(item_q.chan_e);
  assign mix_full  = (CHAN_SUM_W+2)'(chan_sum) * (CHAN_SUM_W+2)'(amrb_pkg::MIX_GAIN);
  assign mix_level = mix_full[LEVEL_W-1:0];

  // Forward distance from read to write index, checked against the margin both ways
  always_comb begin
    if (write_index >= read_index) begin
      fwd_gap = DIST_W'(write_index) - DIST_W'(read_index);
    end else begin
      fwd_gap = DIST_W'(write_index) + DEPTH_D - DIST_W'(read_index);
    end
    dist_back  = DEPTH_D - fwd_gap;
    near       = (fwd_gap < DIST_W'(resync_margin)) ||
                 (dist_back < DIST_W'(resync_margin));
    half_ahead = DIST_W'(read_index) + DIST_W'(IDX_HALF);
    if (half_ahead >= DEPTH_D) begin
      half_ahead = half_ahead - DEPTH_D;
    end
  end

  assign do_check  = (item_q.action == amrb_pkg::ACT_EMPTY) ||
                     (item_q.action == amrb_pkg::ACT_PUSH && item_q.frame_first);
  assign do_resync = do_check && near;

  assign push_index     = do_resync ? half_ahead[IDX_W-1:0] : write_index;
  assign push_index_inc = (push_index == IDX_LAST) ? '0 : push_index + 1'b1;

  // Frame extremes, restarted on the first sample of a frame
  assign base_min = item_q.frame_first ? amrb_pkg::MIN_RESET : frame_min;
  assign base_max = item_q.frame_first ? '0 : frame_max;
  assign new_min  = (mix_level < base_min) ? mix_level : base_min;
  assign new_max  = (mix_level > base_max) ? mix_level : base_max;

  // Result of the item in execution
  always_comb begin
    result_next              = '0;
    result_next.resynced     = do_resync;
    result_next.resync_count = resync_total + (amrb_pkg::COUNT_W)'(do_resync);
    unique case (item_q.action)
      amrb_pkg::ACT_PUSH: begin
        if (item_q.frame_last) begin
          result_next.peak_to_peak = new_max - new_min;
          result_next.p2p_valid    = 1'b1;
        end
      end
      amrb_pkg::ACT_PLAY: begin
        result_next.dac_level = rd_data;
      end
      amrb_pkg::ACT_SILENCE: begin
        result_next.p2p_valid = 1'b0;
      end
      amrb_pkg::ACT_EMPTY: begin
        result_next.p2p_valid = 1'b1;
      end
      default: begin
        result_next.p2p_valid = 1'b0;
      end
    endcase
  end

  // Control state and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= amrb_pkg::ST_SWEEP;
      sweep_idx    <= '0;
      write_index  <= IDX_HALF;
      read_index   <= '0;
      last_level   <= '0;
      frame_min    <= amrb_pkg::MIN_RESET;
      frame_max    <= '0;
      resync_total <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == amrb_pkg::ST_SWEEP) begin
        sweep_idx <= sweep_end ? '0 : sweep_idx + 1'b1;
      end
      if (exec_go) begin
        result_valid <= 1'b1;
        resync_total <= result_next.resync_count;
        unique case (item_q.action)
          amrb_pkg::ACT_PUSH: begin
            write_index <= push_index_inc;
            last_level  <= mix_level;
            if (item_q.frame_last) begin
              frame_min <= amrb_pkg::MIN_RESET;
              frame_max <= '0;
            end else begin
              frame_min <= new_min;
              frame_max <= new_max;
            end
          end
          amrb_pkg::ACT_PLAY: begin
            read_index <= (read_index == IDX_LAST) ? '0 : read_index + 1'b1;
          end
          amrb_pkg::ACT_SILENCE: begin
            last_level <= last_level;
          end
          amrb_pkg::ACT_EMPTY: begin
            write_index <= push_index;
            frame_min   <= amrb_pkg::MIN_RESET;
            frame_max   <= '0;
          end
          default: begin
            last_level <= last_level;
          end
        endcase
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Item capture and result register
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
    if (exec_go) begin
      result <= result_next;
    end
  end

endmodule

FILE: tb/audio_mix_ring_buffer_resync_checker.sv
`timescale 1ns / 1ps

module audio_mix_ring_buffer_resync_checker
  import amrb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [MARGIN_W-1:0] cfg_data,
  input  logic                item_valid,
  input  logic                item_stall,
  input  item_t               item,
  input  logic                result_valid,
  input  logic                result_stall,
  input  result_t             result,
  output int                  mismatches,
  output int                  awaited,
  output int                  checked,
  output int                  resyncs
);

  localparam int REPORT_CAP = 100;

  // Predicted copy of the ring and its bookkeeping.
  logic [LEVEL_W-1:0]  ring_mem [0:RING_DEPTH-1];
  logic [IDX_W-1:0]    wr_pos;
  logic [IDX_W-1:0]    rd_pos;
  logic [LEVEL_W-1:0]  held_level;
  logic [LEVEL_W-1:0]  lo_level;
  logic [LEVEL_W-1:0]  hi_level;
  logic [COUNT_W-1:0]  resync_tally;
  logic [MARGIN_W-1:0] margin_now;

  // Results predicted for accepted items, oldest first.
  result_t awaited_ring_out [$];

  function automatic void restart_frame();
    lo_level = MIN_RESET;
    hi_level = '0;
  endfunction

  // Pull the write index half a ring ahead of the read index when the two
  // have come closer than the margin in either direction.
  function automatic logic recentre_if_close();
    logic [IDX_W-1:0] gap;
    int               span;
    gap  = wr_pos - rd_pos;
    span = int'(gap);
    if (span < int'(margin_now) || (RING_DEPTH - span) < int'(margin_now)) begin
      wr_pos       = rd_pos + IDX_W'(RING_DEPTH / 2);
      resync_tally = resync_tally + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one item to the predicted ring and return the result it should give.
  function automatic result_t advance_ring(input item_t it);
    result_t            out;
    logic [LEVEL_W-1:0] lvl;
    int                 total;
    out = '0;
    case (it.action)
      ACT_PUSH: begin
        total = int'(it.chan_a) + int'(it.chan_b) + int'(it.chan_c) +
                int'(it.chan_d) + int'(it.chan_e);
        lvl = LEVEL_W'(total * MIX_GAIN);
        if (it.frame_first) begin
          out.resynced = recentre_if_close();
          restart_frame();
        end
        ring_mem[wr_pos] = lvl;
        wr_pos           = wr_pos + 1'b1;
        held_level       = lvl;
        if (lvl < lo_level) lo_level = lvl;
        if (lvl > hi_level) hi_level = lvl;
        if (it.frame_last) begin
          out.peak_to_peak = hi_level - lo_level;
          out.p2p_valid    = 1'b1;
          restart_frame();
        end
      end
      ACT_PLAY: begin
        out.dac_level = ring_mem[rd_pos];
        rd_pos        = rd_pos + 1'b1;
      end
      ACT_SILENCE: begin
        for (int k = 0; k < RING_DEPTH; k++) ring_mem[k] = held_level;
      end
      default: begin
        out.resynced  = recentre_if_close();
        restart_frame();
        out.p2p_valid = 1'b1;
      end
    endcase
    out.resync_count = resync_tally;
    return out;
  endfunction

  // Watch the three channels. A result transfer is matched before an item
  // transfer on the same edge, since it can only belong to an earlier item.
  // Reports list dac level, peak-to-peak, p2p valid, resynced and count.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int k = 0; k < RING_DEPTH; k++) ring_mem[k] = '0;
      wr_pos       = IDX_W'(RING_DEPTH / 2);
      rd_pos       = '0;
      held_level   = '0;
      resync_tally = '0;
      margin_now   = MARGIN_RESET;
      restart_frame();
      awaited_ring_out.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_valid && cfg_ready) margin_now = cfg_data;

      if (result_valid && !result_stall) begin
        checked = checked + 1;
        if (awaited_ring_out.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_CAP)
            $display("%0t: unexpected result, got %0d %0d %0b %0b %0d",
                     $time, result.dac_level, result.peak_to_peak, result.p2p_valid,
                     result.resynced, result.resync_count);
        end else begin
          want = awaited_ring_out.pop_front();
          if (result.dac_level !== want.dac_level ||
              result.peak_to_peak !== want.peak_to_peak ||
              result.p2p_valid !== want.p2p_valid || result.resynced !== want.resynced ||
              result.resync_count !== want.resync_count) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_CAP)
              $display("%0t: expected %0d %0d %0b %0b %0d, got %0d %0d %0b %0b %0d",
                       $time, want.dac_level, want.peak_to_peak, want.p2p_valid,
                       want.resynced, want.resync_count, result.dac_level,
                       result.peak_to_peak, result.p2p_valid, result.resynced,
                       result.resync_count);
          end
        end
      end

      if (item_valid && !item_stall) awaited_ring_out.push_back(advance_ring(item));
    end
    awaited = awaited_ring_out.size();
    resyncs = int'(resync_tally);
  end

endmodule

FILE: tb/audio_mix_ring_buffer_resync_tb.sv
`timescale 1ns / 1ps

module audio_mix_ring_buffer_resync_tb;
  import amrb_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 110;
  localparam int SETTLE_CYCLES = 6;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [MARGIN_W-1:0] cfg_data;
  logic                item_valid;
  logic                item_stall;
  item_t               item;
  logic                result_valid;
  logic                result_stall;
  result_t             result;

  int mismatches;
  int awaited;
  int checked;
  int resyncs;

  int cycle_count;
  int items_sent;
  int cfg_writes;
  int act_count [4];
  bit gaps_on;
  bit stalls_on;
  bit calm_tail;

  audio_mix_ring_buffer_resync DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  audio_mix_ring_buffer_resync_checker ring_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .checked      (checked),
    .resyncs      (resyncs)
  );

  // Clock and cycle counter.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Give up on a run that never finishes.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("audio_mix_ring_buffer_resync verification failed");
    $finish;
  end

  // Result side: stall in bursts, with quiet stretches and none at the tail.
  initial begin
    result_stall = 1'b0;
    stalls_on    = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 149) == 0) stalls_on = !stalls_on;
      if (!rst && !calm_tail && stalls_on && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Random item with the given action; channels lean towards their extremes now and then.
  function automatic item_t random_item(input action_t act);
    item_t it;
    logic [CHAN_W-1:0] lv [5];
    for (int k = 0; k < 5; k++) begin
      if ($urandom_range(0, 7) == 0) lv[k] = $urandom_range(0, 1) ? '1 : '0;
      else lv[k] = CHAN_W'($urandom_range(0, 255));
    end
    it.action      = act;
    it.chan_a      = lv[0];
    it.chan_b      = lv[1];
    it.chan_c      = lv[2];
    it.chan_d      = lv[3];
    it.chan_e      = lv[4];
    it.frame_first = 1'($urandom_range(0, 1));
    it.frame_last  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic item_t level_push(input int a, input int b, input int c, input int d,
                                       input int e, input bit first, input bit last);
    item_t it;
    it.action      = ACT_PUSH;
    it.chan_a      = CHAN_W'(a);
    it.chan_b      = CHAN_W'(b);
    it.chan_c      = CHAN_W'(c);
    it.chan_d      = CHAN_W'(d);
    it.chan_e      = CHAN_W'(e);
    it.frame_first = first;
    it.frame_last  = last;
    return it;
  endfunction

  // One item transfer, called at a falling edge; may leave a gap afterwards.
  task automatic send_item(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent = items_sent + 1;
    act_count[it.action] = act_count[it.action] + 1;
    @(negedge clk);
    if ($urandom_range(0, 149) == 0) gaps_on = !gaps_on;
    if (!calm_tail && gaps_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic drain_ring();
    item_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_margin(input logic [MARGIN_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    cfg_writes = cfg_writes + 1;
  endtask

  // A well-formed frame of pushes, with play ticks mixed in according to the
  // push share so that the two indexes drift towards each other or apart.
  task automatic send_frame(input int push_pct);
    int len;
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) >= push_pct)
        repeat ($urandom_range(1, 3)) send_item(random_item(ACT_PLAY));
      send_item(level_push($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), k == 0, k == len - 1));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int margins  [PHASES];
    int push_pct [PHASES];
    int phase_start;
    int roll;
    bit paused;
    logic [MARGIN_W-1:0] m;

    margins  = '{0, 1023, 1, 1000, -1, 512, -2, 256};
    push_pct = '{80, 50, 20, 85, 15, 50, 60, 50};

    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    item_valid  = 1'b0;
    item        = '0;
    cycle_count = 0;
    items_sent  = 0;
    cfg_writes  = 0;
    gaps_on     = 1'b1;
    calm_tail   = 1'b0;
    foreach (act_count[k]) act_count[k] = 0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset margin.
    // Silence before any push fills with zero.
    send_item(random_item(ACT_SILENCE));
    send_item(random_item(ACT_PLAY));
    // Single-sample frames at both channel extremes.
    send_item(level_push(0, 0, 0, 0, 0, 1, 1));
    send_item(level_push(255, 255, 255, 255, 255, 1, 1));
    // A three-sample frame.
    send_item(level_push(1, 2, 3, 4, 5, 1, 0));
    send_item(level_push(255, 0, 255, 0, 255, 0, 0));
    send_item(level_push(0, 0, 0, 0, 1, 0, 1));
    // Pushes without a frame start keep accumulating the minimum and maximum.
    send_item(level_push(100, 100, 100, 100, 100, 0, 0));
    send_item(level_push(200, 200, 200, 200, 200, 0, 0));
    send_item(level_push(0, 0, 0, 0, 0, 0, 1));
    // Empty frames, and a play tick with stray frame bits and channels.
    send_item(random_item(ACT_EMPTY));
    send_item(level_push(9, 9, 9, 9, 9, 1, 0));
    send_item(random_item(ACT_EMPTY));
    send_item(level_push(255, 255, 255, 255, 255, 1, 1));
    send_item(random_item(ACT_PLAY));
    // A frame restarted by a second frame start.
    send_item(level_push(50, 60, 70, 80, 90, 1, 0));
    send_item(level_push(3, 3, 3, 3, 3, 1, 0));
    send_item(level_push(4, 4, 4, 4, 4, 0, 1));
    // Silence with the last level of a push, then read it back.
    send_item(level_push(7, 7, 7, 7, 7, 1, 1));
    send_item(random_item(ACT_SILENCE));
    send_item(random_item(ACT_PLAY));
    send_item(random_item(ACT_PLAY));

    // Random phases, each with its own margin and push share.
    for (int p = 0; p < PHASES; p++) begin
      drain_ring();
      if (margins[p] == -1) m = MARGIN_W'($urandom_range(900, 1023));
      else if (margins[p] == -2) m = MARGIN_W'($urandom_range(0, 1023));
      else m = MARGIN_W'(margins[p]);
      program_margin(m);
      calm_tail   = (p == PHASES - 1);
      phase_start = items_sent;
      paused      = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          drain_ring();
          paused = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          send_frame(push_pct[p]);
        end else if (roll < 82) begin
          send_item(random_item(ACT_EMPTY));
        end else if (roll < 84) begin
          send_item(random_item(ACT_SILENCE));
        end else begin
          // Loose items with arbitrary frame bits; silence kept rare.
          roll = $urandom_range(0, 3);
          if (roll == int'(ACT_SILENCE) && $urandom_range(0, 9) != 0) roll = int'(ACT_PLAY);
          send_item(random_item(action_t'(roll)));
        end
      end
    end

    drain_ring();
    repeat (20) @(negedge clk);

    $display("Run covered %0d items: %0d pushes, %0d play ticks, %0d silence fills, %0d empty frames.",
             items_sent, act_count[ACT_PUSH], act_count[ACT_PLAY],
             act_count[ACT_SILENCE], act_count[ACT_EMPTY]);
    $display("%0d results checked, %0d margin writes, %0d resyncs predicted.",
             checked, cfg_writes, resyncs);
    if (mismatches == 0 && awaited == 0) begin
      $display("audio_mix_ring_buffer_resync verification clean");
    end else begin
      $display("audio_mix_ring_buffer_resync verification failed");
    end
    $finish;
  end

endmodule
